// ===== hdl/dst_pkg.sv =====
// dst_pkg: sizes, codes and item types for the descriptor slot table.
// Used by dst_ctrl, dst_datapath and descriptor_slot_table_unit.
`default_nettype none

package dst_pkg;

    localparam int TABLE_SLOTS = 1024;
    localparam int HANDLE_BITS = 16;

    // slot number width and a width wide enough to compare against the limit
    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int CMP_W  = (SLOT_W + 1 > 11) ? SLOT_W + 1 : 11;

    // handle bits actually kept (input field is 16 bits wide)
    localparam int KEEP_W = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;

    // occupancy is held as rows of ROW_BITS flags
    localparam int ROW_BITS = (TABLE_SLOTS >= 32) ? 32 : (1 << SLOT_W);
    localparam int ROW_W    = $clog2(ROW_BITS);
    localparam int ROWS     = (TABLE_SLOTS + ROW_BITS - 1) / ROW_BITS;
    localparam int RADDR_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic [10:0] LIMIT_RESET = 11'd1024;

    typedef enum logic [1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_FREE   = 2'd1,
        REQ_LOOKUP = 2'd2
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_INVAL = 2'd1,
        ST_BADF  = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [9:0]  slot_index;
        logic [15:0] handle_in;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [9:0]  slot_out;
        logic [15:0] handle_out;
        logic        ref_add;
        logic        ref_drop;
    } out_item_t;

    typedef struct packed {
        logic issue;   // capture request and read both memories
        logic commit;  // write memories and load the result register
    } dst_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/dst_ctrl.sv =====
// dst_ctrl: two-state sequencer and result-valid flag for the slot table.
// Depends on dst_pkg.
`default_nettype none

module dst_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output dst_pkg::dst_cmd_t      cmd
);

    dst_pkg::state_t state_reg;
    dst_pkg::state_t state_next;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    logic            out_free;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dst_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd.issue  = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            dst_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.issue  = 1'b1;
                    state_next = dst_pkg::S_EXEC;
                end
            end
            dst_pkg::S_EXEC:
            begin
                // hold here while the previous item still sits in the result register
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = dst_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dst_pkg::S_IDLE;
            end
        endcase

        if (cmd.commit)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

`ifndef NO_ASSERTIONS
    a_issue_commit_apart: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.issue && cmd.commit))
        else $error("issue and commit in the same cycle");

    a_exec_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dst_pkg::S_EXEC && rsp_valid_reg && !rsp_ready)
        |=> (state_reg == dst_pkg::S_EXEC))
        else $error("left execute state while result register was blocked");

    a_valid_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == dst_pkg::S_EXEC))
        else $error("result valid raised outside execute state");
`endif

endmodule

`default_nettype wire

// ===== hdl/dst_datapath.sv =====
// dst_datapath: limit register, occupancy rows with row flags, handle memory,
// lowest-free search, request evaluation and result register.
// Depends on dst_pkg; driven by dst_ctrl commands.
`default_nettype none

module dst_datapath
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dst_pkg::dst_cmd_t    cmd,
    input  wire dst_pkg::in_item_t    req,
    input  wire logic                 cfg_we,
    input  wire logic [10:0]          cfg_data,
    output dst_pkg::out_item_t        rsp
);

    localparam int SLOT_W   = dst_pkg::SLOT_W;
    localparam int CMP_W    = dst_pkg::CMP_W;
    localparam int KEEP_W   = dst_pkg::KEEP_W;
    localparam int ROW_BITS = dst_pkg::ROW_BITS;
    localparam int ROW_W    = dst_pkg::ROW_W;
    localparam int ROWS     = dst_pkg::ROWS;
    localparam int RADDR_W  = dst_pkg::RADDR_W;

    logic [10:0]         limit_reg;
    logic [CMP_W-1:0]    lim_ext;
    logic [CMP_W-1:0]    lim_eff;

    logic [ROWS-1:0]     row_valid_reg;
    logic [ROWS-1:0]     row_full_reg;

    logic [ROW_BITS-1:0] occ_mem [ROWS];
    logic [KEEP_W-1:0]   hnd_mem [dst_pkg::TABLE_SLOTS];

    logic [RADDR_W-1:0]  free_row;
    logic                any_free;
    logic [CMP_W-1:0]    idx_ext;
    logic [RADDR_W-1:0]  idx_row;
    logic [RADDR_W-1:0]  rd_row;

    dst_pkg::in_item_t   req_q_reg;
    logic [ROW_BITS-1:0] occ_rdata_reg;
    logic                occ_hit_reg;
    logic [KEEP_W-1:0]   hnd_rdata_reg;
    logic [RADDR_W-1:0]  row_sel_reg;
    logic                any_free_reg;

    logic [ROW_BITS-1:0] occ_row;
    logic [ROW_BITS-1:0] new_row;
    logic [ROW_W-1:0]    zero_bit;
    logic                zero_found;
    logic [CMP_W-1:0]    alloc_slot;
    logic [CMP_W-1:0]    q_idx;
    logic [ROW_W-1:0]    q_bit;
    logic                idx_used;
    logic                idx_in;
    logic [KEEP_W-1:0]   h_keep;
    logic                occ_we;
    logic                hnd_we;

    dst_pkg::status_t    st;
    logic [9:0]          slot_o;
    logic [15:0]         hout;
    logic                add;
    logic                drop;

    dst_pkg::out_item_t  rsp_reg;

    // limit register and its clamp to the table size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= dst_pkg::LIMIT_RESET;
        else if (cfg_we)
            limit_reg <= cfg_data;
    end

    assign lim_ext = CMP_W'(limit_reg);
    assign lim_eff = (lim_ext > CMP_W'(dst_pkg::TABLE_SLOTS))
                   ? CMP_W'(dst_pkg::TABLE_SLOTS) : lim_ext;

    // lowest row that still has a free slot
    always_comb
    begin
        free_row = '0;
        any_free = 1'b0;
        for (int i = ROWS - 1; i >= 0; i--)
        begin
            if (!row_full_reg[i])
            begin
                free_row = RADDR_W'(i);
                any_free = 1'b1;
            end
        end
    end

    assign idx_ext = CMP_W'(req.slot_index);
    assign idx_row = RADDR_W'(idx_ext >> ROW_W);
    assign rd_row  = (req.req_type == dst_pkg::REQ_ALLOC) ? free_row : idx_row;

    // on issue, capture the request and read both memories
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            req_q_reg     <= req;
            occ_rdata_reg <= occ_mem[rd_row];
            occ_hit_reg   <= row_valid_reg[rd_row];
            hnd_rdata_reg <= hnd_mem[idx_ext[SLOT_W-1:0]];
            row_sel_reg   <= rd_row;
            any_free_reg  <= any_free;
        end
    end

    // a row never written reads as all empty
    assign occ_row = occ_hit_reg ? occ_rdata_reg : '0;

    always_comb
    begin
        zero_bit   = '0;
        zero_found = 1'b0;
        for (int b = ROW_BITS - 1; b >= 0; b--)
        begin
            if (!occ_row[b])
            begin
                zero_bit   = ROW_W'(b);
                zero_found = 1'b1;
            end
        end
    end

    assign alloc_slot = (CMP_W'(row_sel_reg) << ROW_W) | CMP_W'(zero_bit);
    assign q_idx      = CMP_W'(req_q_reg.slot_index);
    assign q_bit      = q_idx[ROW_W-1:0];
    assign idx_used   = occ_row[q_bit];
    assign idx_in     = q_idx < lim_eff;
    assign h_keep     = req_q_reg.handle_in[KEEP_W-1:0];

    // in the execute state, evaluate the request
    always_comb
    begin
        st      = dst_pkg::ST_OK;
        slot_o  = req_q_reg.slot_index;
        hout    = '0;
        add     = 1'b0;
        drop    = 1'b0;
        occ_we  = 1'b0;
        hnd_we  = 1'b0;
        new_row = occ_row;
        unique case (req_q_reg.req_type)
            dst_pkg::REQ_ALLOC:
            begin
                if (h_keep == '0)
                    st = dst_pkg::ST_INVAL;
                else if (!any_free_reg || !zero_found || alloc_slot >= lim_eff)
                    st = dst_pkg::ST_FULL;
                else
                begin
                    slot_o            = alloc_slot[9:0];
                    add               = 1'b1;
                    occ_we            = cmd.commit;
                    hnd_we            = cmd.commit;
                    new_row[zero_bit] = 1'b1;
                end
            end
            dst_pkg::REQ_FREE:
            begin
                if (!idx_in || !idx_used)
                    st = dst_pkg::ST_BADF;
                else
                begin
                    hout           = 16'(hnd_rdata_reg);
                    drop           = 1'b1;
                    occ_we         = cmd.commit;
                    new_row[q_bit] = 1'b0;
                end
            end
            dst_pkg::REQ_LOOKUP:
            begin
                if (!idx_in)
                    st = dst_pkg::ST_BADF;
                else if (idx_used)
                begin
                    hout = 16'(hnd_rdata_reg);
                    add  = 1'b1;
                end
            end
            default:
            begin
                st = dst_pkg::ST_INVAL;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (occ_we)
            occ_mem[row_sel_reg] <= new_row;
        if (hnd_we)
            hnd_mem[alloc_slot[SLOT_W-1:0]] <= h_keep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            row_full_reg  <= '0;
        end
        else if (occ_we)
        begin
            row_valid_reg[row_sel_reg] <= 1'b1;
            row_full_reg[row_sel_reg]  <= &new_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_reg.status     <= st;
            rsp_reg.slot_out   <= slot_o;
            rsp_reg.handle_out <= hout;
            rsp_reg.ref_add    <= add;
            rsp_reg.ref_drop   <= drop;
        end
    end

    assign rsp = rsp_reg;

`ifndef NO_ASSERTIONS
    a_full_rows_written: assert property (@(posedge clk) disable iff (!rst_n)
        (row_full_reg & ~row_valid_reg) == '0)
        else $error("row flagged full but never written");

    a_alloc_takes_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_we && req_q_reg.req_type == dst_pkg::REQ_ALLOC) |-> !occ_row[zero_bit])
        else $error("allocation chose an occupied slot");

    a_row_marked_valid: assert property (@(posedge clk) disable iff (!rst_n)
        occ_we |=> row_valid_reg[$past(row_sel_reg)])
        else $error("written row not marked valid");

    a_add_drop_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> !(rsp_reg.ref_add && rsp_reg.ref_drop))
        else $error("result asks to add and drop a reference at once");
`endif

endmodule

`default_nettype wire

// ===== hdl/descriptor_slot_table_unit.sv =====
// descriptor_slot_table_unit: top level of the descriptor slot table.
// Instantiates dst_ctrl and dst_datapath; types from dst_pkg.
//
//   channel | signals                   | direction | payload
//   --------+---------------------------+-----------+-------------------------
//   req     | req_valid, req_ready      | in        | dst_pkg::in_item_t
//   rsp     | rsp_valid, rsp_ready      | out       | dst_pkg::out_item_t
//   cfg     | cfg_valid, cfg_ready      | in        | slot_limit, 11 bits
//
// Each item is accepted with its memory read, then evaluated and written back.
// The lowest free slot comes from a priority encoder over per-row full flags
// and a second one inside the selected occupancy row.
// Reset clears the row valid and full flags at once; no clearing pass is needed.
// A result held in the output register stalls evaluation and write-back until taken;
// the next item is accepted while a result waits.
// cfg_ready is always high.
`default_nettype none

module descriptor_slot_table_unit
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire dst_pkg::in_item_t    req,
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output dst_pkg::out_item_t        rsp,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [10:0]          cfg_data
);

    dst_pkg::dst_cmd_t cmd;

    assign cfg_ready = 1'b1;

    dst_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    dst_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req      (req),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire
